>>> rtl/fqr_pkg.sv
package fqr_pkg;

  parameter int unsigned DEPTH       = 16;
  parameter int unsigned WORD_BITS   = 32;

  parameter int unsigned OP_BITS     = 2;
  parameter int unsigned VALUE_BITS  = 32;
  parameter int unsigned DATA_BITS   = 32;
  parameter int unsigned STATUS_BITS = 2;
  parameter int unsigned OCC_BITS    = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

>>> rtl/fqr_if.sv
interface fqr_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [fqr_pkg::OP_BITS-1:0]      operation;
  logic signed [fqr_pkg::VALUE_BITS-1:0]   value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface fqr_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fqr_pkg::DATA_BITS-1:0]    data;
  logic        [fqr_pkg::STATUS_BITS-1:0]  status;
  logic                                    now_empty;
  logic        [fqr_pkg::OCC_BITS-1:0]     occupancy;

  modport source (output valid, data, status, now_empty, occupancy, input ready);
  modport sink   (input valid, data, status, now_empty, occupancy, output ready);
endinterface

>>> rtl/fqr_mem.sv
module fqr_mem #(
  parameter int unsigned DEPTH     = fqr_pkg::DEPTH,
  parameter int unsigned WORD_BITS = fqr_pkg::WORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic signed [WORD_BITS-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic signed [WORD_BITS-1:0]   rdata_o
);

  logic signed [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/fqr_ctrl.sv
module fqr_ctrl #(
  parameter int unsigned DEPTH     = fqr_pkg::DEPTH,
  parameter int unsigned WORD_BITS = fqr_pkg::WORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fqr_req_if.sink                       req_i,
  fqr_rsp_if.source                     rsp_o,
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output logic signed [WORD_BITS-1:0]   mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  input  logic signed [WORD_BITS-1:0]   mem_rdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEQ   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  state_e                               state_q, state_d;
  logic [AW-1:0]                        head_q, head_d;
  logic [CW-1:0]                        cnt_q, cnt_d;
  logic [CW-1:0]                        pos_q, pos_d;
  logic signed [WORD_BITS-1:0]          word_q, word_d;
  logic signed [fqr_pkg::DATA_BITS-1:0] res_data_q, res_data_d;
  fqr_pkg::status_e                     res_status_q, res_status_d;

  logic                                 out_valid_q, out_valid_d;
  logic                                 out_load;
  logic signed [fqr_pkg::DATA_BITS-1:0] out_data_q;
  fqr_pkg::status_e                     out_status_q;
  logic                                 out_empty_q;
  logic [fqr_pkg::OCC_BITS-1:0]         out_occ_q;

  logic signed [WORD_BITS-1:0]          word_in;
  fqr_pkg::op_e                         op_in;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign word_in     = WORD_BITS'(req_i.value);
  assign op_in       = fqr_pkg::op_e'(req_i.operation);
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    word_d       = word_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = wrap_add(head_q, cnt_q);
    mem_wdata_o  = word_in;
    mem_re_o     = 1'b0;
    mem_raddr_o  = head_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          word_d       = word_in;
          res_data_d   = '0;
          res_status_d = fqr_pkg::ST_OK;
          state_d      = S_HOLD;
          unique case (op_in)
            fqr_pkg::OP_ENQ: begin
              if (cnt_q == CW'(DEPTH)) begin
                res_status_d = fqr_pkg::ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                cnt_d    = cnt_q + CW'(1);
              end
            end
            fqr_pkg::OP_DEQ: begin
              if (cnt_q == '0) begin
                res_status_d = fqr_pkg::ST_EMPTY;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_DEQ;
              end
            end
            fqr_pkg::OP_REMOVE: begin
              if (cnt_q == '0) begin
                res_status_d = fqr_pkg::ST_NOT_FOUND;
              end else begin
                mem_re_o = 1'b1;
                pos_d    = '0;
                state_d  = S_SCAN;
              end
            end
            fqr_pkg::OP_CLEAR: begin
              cnt_d  = '0;
              head_d = '0;
            end
            default: begin
              state_d = S_HOLD;
            end
          endcase
        end
      end
      S_DEQ: begin
        res_data_d = fqr_pkg::DATA_BITS'(mem_rdata_i);
        head_d     = wrap_add(head_q, CW'(1));
        cnt_d      = cnt_q - CW'(1);
        state_d    = S_HOLD;
      end
      S_SCAN: begin
        // data of entry pos_q arrives this cycle; the next entry is read unless this is the last one
        if (mem_rdata_i == word_q) begin
          if (pos_q + CW'(1) == cnt_q) begin
            cnt_d   = cnt_q - CW'(1);
            state_d = S_HOLD;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = wrap_add(head_q, pos_q + CW'(1));
            state_d     = S_SHIFT;
          end
        end else if (pos_q + CW'(1) == cnt_q) begin
          res_status_d = fqr_pkg::ST_NOT_FOUND;
          state_d      = S_HOLD;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = wrap_add(head_q, pos_q + CW'(1));
          pos_d       = pos_q + CW'(1);
        end
      end
      S_SHIFT: begin
        // entry pos_q+1 arrives, written to pos_q; read of pos_q+2 overlaps
        mem_we_o    = 1'b1;
        mem_waddr_o = wrap_add(head_q, pos_q);
        mem_wdata_o = mem_rdata_i;
        if (pos_q + CW'(2) == cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_HOLD;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = wrap_add(head_q, pos_q + CW'(2));
          pos_d       = pos_q + CW'(1);
        end
      end
      S_HOLD: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    word_q       <= word_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
      out_empty_q  <= (cnt_q == '0);
      out_occ_q    <= fqr_pkg::OCC_BITS'(cnt_q);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.data      = out_data_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.now_empty = out_empty_q;
  assign rsp_o.occupancy = out_occ_q;

endmodule

>>> rtl/fifo_queue_with_remove.sv
// Bounded FIFO of signed words with enqueue, dequeue, remove-by-value and clear.
// req_i (sink): operation and value; a transfer happens when valid and ready are high.
// rsp_o (source): data, status, now_empty and occupancy, one result per request.
// Entries live in a circular buffer in a one-read, one-write synchronous memory.
// Path from request transfer to result valid, with n entries held:
//   enqueue, clear, dequeue on empty and remove on empty go straight to the
//   result hold state; dequeue first reads the head entry; remove with n > 0
//   scans each entry up to the match (all n on a miss), then compacts every
//   entry behind it. The memory read port reads one entry per cycle.
// One request is worked on at a time; ready returns in the cycle the result
// enters the output register, so a new request can be taken while the last
// result still waits. When the receiver stalls with a result pending, the next
// result is held internally and ready stays low until it moves out.
// Reset empties the queue and drops any pending result; memory contents are
// not cleared and need no clearing pass.
module fifo_queue_with_remove #(
  parameter int unsigned DEPTH     = fqr_pkg::DEPTH,
  parameter int unsigned WORD_BITS = fqr_pkg::WORD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqr_req_if.sink   req_i,
  fqr_rsp_if.source rsp_o
);

  logic                          mem_we;
  logic [$clog2(DEPTH)-1:0]      mem_waddr;
  logic signed [WORD_BITS-1:0]   mem_wdata;
  logic                          mem_re;
  logic [$clog2(DEPTH)-1:0]      mem_raddr;
  logic signed [WORD_BITS-1:0]   mem_rdata;

  fqr_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fqr_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while previous one in flight");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != fqr_pkg::ST_OK |-> rsp_o.data == '0)
    else $error("nonzero data on error result");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == fqr_pkg::ST_FULL
      |-> rsp_o.occupancy == fqr_pkg::OCC_BITS'(DEPTH) && !rsp_o.now_empty)
    else $error("full status with queue not full");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == fqr_pkg::ST_EMPTY |-> rsp_o.now_empty)
    else $error("empty status with entries held");

  a_no_write_at_accept_of_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("memory read and write collide on one entry");

endmodule

>>> dv/fifo_queue_with_remove_tb.sv
module fifo_queue_with_remove_tb;
  import fqr_pkg::*;

  typedef logic        [WORD_BITS-1:0]  word_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] data;
    status_e                     status;
    logic                        now_empty;
    logic        [OCC_BITS-1:0]  occupancy;
  } queue_result_t;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 2 * DEPTH + 8;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam value_t      VALUE_MIN     = 32'sh8000_0000;
  localparam value_t      VALUE_MAX     = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;

  fqr_req_if req_if ();
  fqr_rsp_if rsp_if ();

  fifo_queue_with_remove uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  word_t         held_words[$];
  queue_result_t expected_results[$];
  int unsigned   mismatch_count;
  int unsigned   result_count;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_requests;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic queue_result_t predict_queue_op(op_e op, value_t value);
    queue_result_t res;
    word_t         w;
    w             = word_t'(value);
    res.data      = '0;
    res.status    = ST_OK;
    case (op)
      OP_ENQ: begin
        if (held_words.size() >= DEPTH) res.status = ST_FULL;
        else held_words.push_back(w);
      end
      OP_DEQ: begin
        if (held_words.size() == 0) res.status = ST_EMPTY;
        else res.data = DATA_BITS'($signed(held_words.pop_front()));
      end
      OP_REMOVE: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < held_words.size(); i++) begin
          if (held_words[i] == w) begin
            held_words.delete(i);
            res.status = ST_OK;
            break;
          end
        end
      end
      default: held_words.delete();
    endcase
    res.now_empty = (held_words.size() == 0);
    res.occupancy = OCC_BITS'(held_words.size());
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("result %0d: %s", result_count, msg);
    mismatch_count++;
  endtask

  // one request; valid stays up when the next call follows without a gap
  task automatic send_request(op_e op, value_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= value;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    expected_results.push_back(predict_queue_op(op, value));
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result");
      end else begin
        exp_res = expected_results.pop_front();
        if (rsp_if.data !== exp_res.data)
          report_mismatch($sformatf("data %0d, expected %0d", rsp_if.data, exp_res.data));
        if (rsp_if.status !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status,
                                    exp_res.status));
        if (rsp_if.now_empty !== exp_res.now_empty)
          report_mismatch($sformatf("now_empty %0b, expected %0b", rsp_if.now_empty,
                                    exp_res.now_empty));
        if (rsp_if.occupancy !== exp_res.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d", rsp_if.occupancy,
                                    exp_res.occupancy));
      end
      result_count++;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  int unsigned hold_served;
  int unsigned hold_left;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic value_t pool_value();
    int unsigned pick;
    pick = $urandom_range(7);
    case (pick)
      6:       return VALUE_MIN;
      7:       return VALUE_MAX;
      default: return value_t'(int'(pick) - 3);
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(OP_DEQ, 32'sd0);
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_CLEAR, VALUE_MIN);
  endtask

  task automatic test_fill_to_full();
    value_t fill_values[16];
    fill_values = '{VALUE_MIN, VALUE_MAX, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd7, 32'sd5,
                    32'sd9, 32'sd11, 32'sd13, 32'sd15, 32'sd17, 32'sd19, 32'sd21, 32'sd23};
    foreach (fill_values[i]) send_request(OP_ENQ, fill_values[i]);
    send_request(OP_ENQ, 32'sd99);
  endtask

  task automatic test_remove_positions();
    send_request(OP_REMOVE, VALUE_MIN);
    send_request(OP_REMOVE, 32'sd23);
    send_request(OP_REMOVE, 32'sd5);
    send_request(OP_REMOVE, 32'sd12345);
    send_request(OP_DEQ, VALUE_MAX);
    send_request(OP_CLEAR, VALUE_MAX);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned r;
    op_e         op;
    value_t      value;
    bit          filling;
    for (int unsigned i = 0; i < n_items; i++) begin
      filling = ((i / 40) % 2) == 0;
      r = $urandom_range(99);
      if (filling) begin
        if (r < 65)      op = OP_ENQ;
        else if (r < 77) op = OP_DEQ;
        else if (r < 98) op = OP_REMOVE;
        else             op = OP_CLEAR;
      end else begin
        if (r < 25)      op = OP_ENQ;
        else if (r < 65) op = OP_DEQ;
        else if (r < 98) op = OP_REMOVE;
        else             op = OP_CLEAR;
      end
      value = value_t'($urandom);
      if (op == OP_REMOVE && held_words.size() != 0 && $urandom_range(99) < 65)
        value = value_t'($signed(held_words[$urandom_range(held_words.size() - 1)]));
      else if (op != OP_DEQ && op != OP_CLEAR && $urandom_range(1) == 0)
        value = pool_value();
      send_request(op, value);
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int unsigned i = 0; i < 40; i++) begin
      if ($urandom_range(3) == 0) send_request(OP_REMOVE, pool_value());
      else send_request(OP_ENQ, pool_value());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_ENQ;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
    mismatch_count   = 0;
    result_count     = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_requests    = 0;
    hold_served      = 0;
    hold_left        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_to_full();
    test_remove_positions();
    wait_for_drain();

    test_random_traffic(190);
    wait_for_drain();

    send_idle_pct  = 74;
    recv_stall_pct = 0;
    test_random_traffic(190);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 74;
    test_random_traffic(190);
    wait_for_drain();

    send_idle_pct  = 35;
    recv_stall_pct = 35;
    test_random_traffic(190);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fqr_pkg.sv
rtl/fqr_if.sv
rtl/fqr_mem.sv
rtl/fqr_ctrl.sv
rtl/fifo_queue_with_remove.sv
dv/fifo_queue_with_remove_tb.sv
